// File: rtl/mfrq_pkg.sv
`default_nettype none

package mfrq_pkg;

    localparam int KIND_W     = 2;
    localparam int TID_W      = 6;
    localparam int STATUS_W   = 2;
    localparam int RUN_LVL_W  = 4;
    localparam int TICK_W     = 32;
    localparam int TOTAL_W    = 7;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SLICE_UNIT      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RELINK_INTERVAL = 1'd1;

    localparam logic [CFG_DATA_W-1:0] SLICE_UNIT_RESET      = 16'd1;
    localparam logic [CFG_DATA_W-1:0] RELINK_INTERVAL_RESET = 16'd100;

    typedef enum logic [KIND_W-1:0] {
        K_WAKE     = 2'd0,
        K_SCHEDULE = 2'd1,
        K_TICK     = 2'd2,
        K_NOP      = 2'd3
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE     = 2'd0,
        ST_SWITCHED = 2'd1,
        ST_KEPT     = 2'd2,
        ST_IDLE     = 2'd3
    } t_status;

    typedef struct packed {
        logic read;
        logic exec;
        logic wr2;
    } t_ctrl;

    typedef struct packed {
        t_status               status;
        logic                  run_valid;
        logic [TID_W-1:0]      run_thread;
        logic [RUN_LVL_W-1:0]  run_level;
        logic [TICK_W-1:0]     slice_deadline;
        logic [TOTAL_W-1:0]    ready_total;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/mfrq_if.sv
`default_nettype none

interface mfrq_item_if;
    import mfrq_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [TID_W-1:0]  thread_id;
    logic              leave_mode;

    modport source (output valid, kind, thread_id, leave_mode, input ready);
    modport sink   (input valid, kind, thread_id, leave_mode, output ready);
endinterface

interface mfrq_result_if;
    import mfrq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic                 run_valid;
    logic [TID_W-1:0]     run_thread;
    logic [RUN_LVL_W-1:0] run_level;
    logic [TICK_W-1:0]    slice_deadline;
    logic [TOTAL_W-1:0]   ready_total;

    modport source (output valid, status, run_valid, run_thread, run_level,
                    slice_deadline, ready_total, input ready);
    modport sink   (input valid, status, run_valid, run_thread, run_level,
                    slice_deadline, ready_total, output ready);
endinterface

interface mfrq_cfg_if;
    import mfrq_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

`default_nettype wire

// File: rtl/mfrq_link_mem.sv
`default_nettype none

module mfrq_link_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 6
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/mfrq_core.sv
`default_nettype none

module mfrq_core
    import mfrq_pkg::*;
#(
    parameter int LEVELS  = 16,
    parameter int THREADS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ctrl                 i_ctrl,
    input  wire t_kind                 i_kind,
    input  wire logic [TID_W-1:0]      i_thread_id,
    input  wire logic                  i_leave_mode,
    input  wire logic [CFG_DATA_W-1:0] i_slice_unit,
    input  wire logic [CFG_DATA_W-1:0] i_relink_interval,
    output logic                       o_need_wr2,
    output t_result                    o_result
);

    localparam int TW = $clog2(THREADS);
    localparam int LW = $clog2(LEVELS);
    localparam int CW = $clog2(THREADS + 1);
    localparam logic [LW-1:0] LAST_LVL = LW'(LEVELS - 1);

    logic [TW-1:0]     r_head [LEVELS];
    logic [TW-1:0]     r_tail [LEVELS];
    logic [CW-1:0]     r_count [LEVELS];
    logic [CW-1:0]     r_sum;
    logic [TW-1:0]     r_cur_tid;
    logic [LW-1:0]     r_cur_lvl;
    logic              r_cur_valid;
    logic [TICK_W-1:0] r_tick;
    logic [TICK_W-1:0] r_due;
    logic [TICK_W-1:0] r_slice;
    logic [LW-1:0]     r_best;
    logic              r_found;
    logic [TW-1:0]     r_p_addr;
    logic [TW-1:0]     r_p_data;

    logic [TW-1:0]     n_head [LEVELS];
    logic [TW-1:0]     n_tail [LEVELS];
    logic [CW-1:0]     n_count [LEVELS];
    logic [CW-1:0]     n_sum;
    logic [TW-1:0]     n_cur_tid;
    logic [LW-1:0]     n_cur_lvl;
    logic              n_cur_valid;
    logic [TICK_W-1:0] n_tick;
    logic [TICK_W-1:0] n_due;
    logic [TICK_W-1:0] n_slice;
    t_status           n_status;

    logic              w_found;
    logic [LW-1:0]     w_best;
    logic [TW-1:0]     w_rdata;
    logic              w1_en;
    logic [TW-1:0]     w1_addr;
    logic [TW-1:0]     w1_data;
    logic              w2_en;
    logic [TW-1:0]     w2_addr;
    logic [TW-1:0]     w2_data;
    logic [TICK_W-1:0] w_age_diff;
    logic [TICK_W-1:0] w_prod;
    logic              mem_wr_en;
    logic [TW-1:0]     mem_wr_addr;
    logic [TW-1:0]     mem_wr_data;

    always_comb begin
        w_found = 1'b0;
        w_best  = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_count[i] != '0) begin
                w_found = 1'b1;
                w_best  = LW'(i);
            end
        end
    end

    assign mem_wr_en   = (i_ctrl.exec && w1_en) || i_ctrl.wr2;
    assign mem_wr_addr = i_ctrl.wr2 ? r_p_addr : w1_addr;
    assign mem_wr_data = i_ctrl.wr2 ? r_p_data : w1_data;

    mfrq_link_mem #(
        .DEPTH (THREADS),
        .WIDTH (TW)
    ) u_link_mem (
        .i_clk     (i_clk),
        .i_rd_en   (i_ctrl.read),
        .i_rd_addr (r_head[w_best]),
        .o_rd_data (w_rdata),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    assign w_age_diff = r_tick - r_due;
    assign w_prod     = 32'({1'b0, r_best} + (LW + 1)'(1)) * 32'(i_slice_unit);

    always_comb begin
        logic [TW-1:0] mh;
        logic [TW-1:0] mt;
        logic [CW-1:0] mn;
        logic [LW-1:0] nl;

        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_sum       = r_sum;
        n_cur_tid   = r_cur_tid;
        n_cur_lvl   = r_cur_lvl;
        n_cur_valid = r_cur_valid;
        n_tick      = r_tick;
        n_due       = r_due;
        n_slice     = r_slice;
        n_status    = ST_DONE;
        w1_en       = 1'b0;
        w1_addr     = '0;
        w1_data     = '0;
        w2_en       = 1'b0;
        w2_addr     = '0;
        w2_data     = '0;
        mh          = '0;
        mt          = '0;
        mn          = '0;
        nl          = '0;

        case (i_kind)
            K_WAKE: begin
                if (32'(i_thread_id) < THREADS && 32'(r_sum) < THREADS) begin
                    if (r_count[0] == '0) begin
                        n_head[0] = TW'(i_thread_id);
                    end else begin
                        w1_en   = 1'b1;
                        w1_addr = r_tail[0];
                        w1_data = TW'(i_thread_id);
                    end
                    n_tail[0]  = TW'(i_thread_id);
                    n_count[0] = r_count[0] + CW'(1);
                    n_sum      = r_sum + CW'(1);
                end
            end
            K_SCHEDULE: begin
                if (!r_found) begin
                    if (r_cur_valid && !i_leave_mode) begin
                        n_status = ST_KEPT;
                    end else begin
                        n_cur_valid = 1'b0;
                        n_status    = ST_IDLE;
                    end
                end else begin
                    n_status    = ST_SWITCHED;
                    n_cur_tid   = r_head[r_best];
                    n_cur_lvl   = r_best;
                    n_cur_valid = 1'b1;
                    if (r_count[r_best] > CW'(1)) begin
                        n_head[r_best] = w_rdata;
                    end
                    n_count[r_best] = r_count[r_best] - CW'(1);
                    n_sum           = r_sum - CW'(1);

                    if (!w_age_diff[TICK_W-1]) begin
                        n_due = r_tick + TICK_W'(i_relink_interval);
                        if (r_best != LAST_LVL) begin
                            mh = r_head[r_best + LW'(1)];
                            mt = r_tail[r_best + LW'(1)];
                            mn = r_count[r_best + LW'(1)];
                            for (int i = 0; i < LEVELS - 1; i++) begin
                                if (LW'(i) > r_best) begin
                                    n_head[i]  = r_head[i + 1];
                                    n_tail[i]  = r_tail[i + 1];
                                    n_count[i] = r_count[i + 1];
                                end
                            end
                            n_count[LEVELS-1] = '0;
                            if (mn != '0) begin
                                if (n_count[r_best] == '0) begin
                                    n_head[r_best] = mh;
                                end else begin
                                    w1_en   = 1'b1;
                                    w1_addr = r_tail[r_best];
                                    w1_data = mh;
                                end
                                n_tail[r_best]  = mt;
                                n_count[r_best] = n_count[r_best] + mn;
                            end
                        end
                    end

                    n_slice = r_tick + w_prod;

                    if (r_cur_valid && !i_leave_mode) begin
                        nl = (r_cur_lvl == LAST_LVL) ? r_cur_lvl : r_cur_lvl + LW'(1);
                        if (32'(n_sum) < THREADS) begin
                            if (n_count[nl] == '0) begin
                                n_head[nl] = r_cur_tid;
                            end else if (w1_en) begin
                                w2_en   = 1'b1;
                                w2_addr = n_tail[nl];
                                w2_data = r_cur_tid;
                            end else begin
                                w1_en   = 1'b1;
                                w1_addr = n_tail[nl];
                                w1_data = r_cur_tid;
                            end
                            n_tail[nl]  = r_cur_tid;
                            n_count[nl] = n_count[nl] + CW'(1);
                            n_sum       = n_sum + CW'(1);
                        end
                    end
                end
            end
            K_TICK: begin
                n_tick = r_tick + TICK_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_need_wr2 = w2_en;

    always_comb begin
        o_result.status         = n_status;
        o_result.run_valid      = n_cur_valid;
        o_result.run_thread     = n_cur_valid ? TID_W'(n_cur_tid) : '0;
        o_result.run_level      = n_cur_valid ? RUN_LVL_W'(n_cur_lvl) : '0;
        o_result.slice_deadline = n_cur_valid ? n_slice : '0;
        o_result.ready_total    = TOTAL_W'(n_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_count[i] <= '0;
            end
            r_sum       <= '0;
            r_cur_tid   <= '0;
            r_cur_lvl   <= '0;
            r_cur_valid <= 1'b0;
            r_tick      <= '0;
            r_due       <= '0;
            r_slice     <= '0;
        end else if (i_ctrl.exec) begin
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_cur_tid   <= n_cur_tid;
            r_cur_lvl   <= n_cur_lvl;
            r_cur_valid <= n_cur_valid;
            r_tick      <= n_tick;
            r_due       <= n_due;
            r_slice     <= n_slice;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.read) begin
            r_best  <= w_best;
            r_found <= w_found;
        end
        if (i_ctrl.exec) begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_p_addr <= w2_addr;
            r_p_data <= w2_data;
        end
    end

endmodule

`default_nettype wire

// File: rtl/multilevel_feedback_run_queue_core.sv
`default_nettype none

// Multilevel feedback run queue for one processor. Wake appends a thread to
// level 0, tick advances a 32-bit wrapping clock, and schedule takes the head
// of the best non-empty level, optionally ages the lower levels up by one,
// requeues a preempted thread one level lower and sets the slice deadline.
// Every accepted transaction returns exactly one result transaction. An item
// passes through a registered read of the next-link memory at the head of the
// best level, then the update into the result register, which stalls while
// that register is full. A new item is accepted only while the block is
// empty or as the last item's update executes; a schedule that both ages a
// level onto a non-empty level and requeues the old thread onto a non-empty
// level needs a second memory write, and the next item is accepted only after
// that write. The configuration channel is always ready and must be written
// only while the block is idle. No clearing pass is needed after reset.
module multilevel_feedback_run_queue_core
    import mfrq_pkg::*;
#(
    parameter int LEVELS  = 16,
    parameter int THREADS = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    mfrq_item_if.sink     i_item,
    mfrq_result_if.source o_result,
    mfrq_cfg_if.sink      i_cfg
);

    typedef enum logic [1:0] {
        S_EMPTY,
        S_READ,
        S_EXEC,
        S_WR2
    } t_state;

    t_state                r_state;
    t_kind                 r_kind;
    logic [TID_W-1:0]      r_tid;
    logic                  r_leave;
    logic                  r_out_valid;
    t_result               r_out;
    logic [CFG_DATA_W-1:0] r_slice_unit;
    logic [CFG_DATA_W-1:0] r_relink_interval;

    t_ctrl   w_ctrl;
    t_result w_result;
    logic    w_need_wr2;
    logic    w_out_free;
    logic    w_exec;
    logic    w_accept;

    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_exec       = (r_state == S_EXEC) && w_out_free;
    assign i_item.ready = (r_state == S_EMPTY) || (w_exec && !w_need_wr2);
    assign w_accept     = i_item.valid && i_item.ready;

    assign w_ctrl.read = (r_state == S_READ);
    assign w_ctrl.exec = w_exec;
    assign w_ctrl.wr2  = (r_state == S_WR2);

    assign i_cfg.ready = 1'b1;

    mfrq_core #(
        .LEVELS  (LEVELS),
        .THREADS (THREADS)
    ) u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctrl            (w_ctrl),
        .i_kind            (r_kind),
        .i_thread_id       (r_tid),
        .i_leave_mode      (r_leave),
        .i_slice_unit      (r_slice_unit),
        .i_relink_interval (r_relink_interval),
        .o_need_wr2        (w_need_wr2),
        .o_result          (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_EMPTY;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_EMPTY: begin
                    if (w_accept) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_exec) begin
                        if (w_need_wr2) begin
                            r_state <= S_WR2;
                        end else if (w_accept) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_EMPTY;
                        end
                    end
                end
                S_WR2: begin
                    r_state <= S_EMPTY;
                end
                default: begin
                    r_state <= S_EMPTY;
                end
            endcase
            if (w_exec) begin
                r_out_valid <= 1'b1;
                r_out       <= w_result;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind  <= t_kind'(i_item.kind);
            r_tid   <= i_item.thread_id;
            r_leave <= i_item.leave_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice_unit      <= SLICE_UNIT_RESET;
            r_relink_interval <= RELINK_INTERVAL_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_SLICE_UNIT:      r_slice_unit      <= i_cfg.reg_data;
                CFG_RELINK_INTERVAL: r_relink_interval <= i_cfg.reg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.status         = r_out.status;
    assign o_result.run_valid      = r_out.run_valid;
    assign o_result.run_thread     = r_out.run_thread;
    assign o_result.run_level      = r_out.run_level;
    assign o_result.slice_deadline = r_out.slice_deadline;
    assign o_result.ready_total    = r_out.ready_total;

endmodule

`default_nettype wire

// File: test/multilevel_feedback_run_queue_core_tb.sv
module multilevel_feedback_run_queue_core_tb;
    import mfrq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVELS      = 16;
    localparam int THREADS     = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASES      = 6;

    typedef struct {
        t_kind               kind;
        logic [TID_W-1:0]    tid;
        logic                leave;
        bit                  fixed;
        t_result             want;
    } t_step_row;

    logic i_clk;
    logic i_rst_n;

    mfrq_item_if   item_bus ();
    mfrq_result_if result_bus ();
    mfrq_cfg_if    cfg_bus ();

    multilevel_feedback_run_queue_core #(
        .LEVELS  (LEVELS),
        .THREADS (THREADS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_bus),
        .o_result (result_bus),
        .i_cfg    (cfg_bus)
    );

    // Scheduler state as the block should hold it.
    logic [TID_W-1:0]     queue_head [LEVELS];
    logic [TID_W-1:0]     queue_tail [LEVELS];
    int                   queue_len  [LEVELS];
    logic [TID_W-1:0]     chain_next [THREADS];
    int                   waiting_total;
    logic [TID_W-1:0]     running_tid;
    logic [RUN_LVL_W-1:0] running_level;
    bit                   running;
    logic [TICK_W-1:0]    tick_now;
    logic [TICK_W-1:0]    aging_due;
    logic [TICK_W-1:0]    slice_stop;
    logic [CFG_DATA_W-1:0] slice_ticks;
    logic [CFG_DATA_W-1:0] aging_gap;

    t_result predicted_runs [$];

    int  mismatches;
    int  results_seen;
    int  items_sent;
    int  cycle_count;
    int  switch_count;
    int  kept_count;
    int  idle_count;
    int  deepest_level;
    int  aging_runs;
    int  dropped_wakes;
    int  hold_count;
    bit  hold_request;

    t_step_row directed_steps [23] = '{
        '{K_SCHEDULE, 6'd0,  1'b0, 1'b1, '{ST_IDLE, 1'b0, 6'd0, 4'd0, 32'd0, 7'd0}},
        '{K_TICK,     6'd63, 1'b1, 1'b1, '{ST_DONE, 1'b0, 6'd0, 4'd0, 32'd0, 7'd0}},
        '{K_NOP,      6'd63, 1'b1, 1'b1, '{ST_DONE, 1'b0, 6'd0, 4'd0, 32'd0, 7'd0}},
        '{K_WAKE,     6'd63, 1'b0, 1'b1, '{ST_DONE, 1'b0, 6'd0, 4'd0, 32'd0, 7'd1}},
        '{K_WAKE,     6'd0,  1'b1, 1'b1, '{ST_DONE, 1'b0, 6'd0, 4'd0, 32'd0, 7'd2}},
        '{K_WAKE,     6'd63, 1'b0, 1'b1, '{ST_DONE, 1'b0, 6'd0, 4'd0, 32'd0, 7'd3}},
        '{K_SCHEDULE, 6'd0,  1'b1, 1'b1, '{ST_SWITCHED, 1'b1, 6'd63, 4'd0, 32'd2, 7'd2}},
        '{K_SCHEDULE, 6'd0,  1'b0, 1'b0, '0},
        '{K_SCHEDULE, 6'd63, 1'b0, 1'b0, '0},
        '{K_TICK,     6'd0,  1'b0, 1'b0, '0},
        '{K_SCHEDULE, 6'd0,  1'b0, 1'b0, '0},
        '{K_SCHEDULE, 6'd0,  1'b1, 1'b0, '0},
        '{K_SCHEDULE, 6'd0,  1'b1, 1'b0, '0},
        '{K_SCHEDULE, 6'd0,  1'b1, 1'b1, '{ST_IDLE, 1'b0, 6'd0, 4'd0, 32'd0, 7'd0}},
        '{K_SCHEDULE, 6'd63, 1'b0, 1'b1, '{ST_IDLE, 1'b0, 6'd0, 4'd0, 32'd0, 7'd0}},
        '{K_WAKE,     6'd21, 1'b0, 1'b1, '{ST_DONE, 1'b0, 6'd0, 4'd0, 32'd0, 7'd1}},
        '{K_SCHEDULE, 6'd0,  1'b1, 1'b0, '0},
        '{K_SCHEDULE, 6'd0,  1'b0, 1'b0, '0},
        '{K_WAKE,     6'd42, 1'b1, 1'b0, '0},
        '{K_TICK,     6'd21, 1'b0, 1'b0, '0},
        '{K_SCHEDULE, 6'd0,  1'b0, 1'b0, '0},
        '{K_NOP,      6'd0,  1'b0, 1'b0, '0},
        '{K_SCHEDULE, 6'd0,  1'b0, 1'b0, '0}
    };

    logic [CFG_DATA_W-1:0] slice_plan [PHASES] = '{16'd65535, 16'd1, 16'd0, 16'd3,
                                                  16'd40000, 16'd1};
    logic [CFG_DATA_W-1:0] gap_plan   [PHASES] = '{16'd1, 16'd65535, 16'd0, 16'd20,
                                                  16'd7, 16'd100};

    function automatic void enqueue_thread(int lvl, logic [TID_W-1:0] tid);
        if (queue_len[lvl] == 0) begin
            queue_head[lvl] = tid;
        end else begin
            chain_next[queue_tail[lvl]] = tid;
        end
        queue_tail[lvl] = tid;
        queue_len[lvl]++;
        waiting_total++;
    endfunction

    function automatic bit dequeue_best(output logic [TID_W-1:0] tid, output int lvl);
        int i;
        tid = '0;
        lvl = 0;
        if (waiting_total == 0) return 1'b0;
        for (i = 0; i < LEVELS; i++) begin
            if (queue_len[i] != 0) begin
                tid = queue_head[i];
                lvl = i;
                if (queue_len[i] > 1) queue_head[i] = chain_next[tid];
                queue_len[i]--;
                waiting_total--;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void age_below(int start);
        logic [TID_W-1:0]  moved_head;
        logic [TID_W-1:0]  moved_tail;
        int                moved_len;
        logic [TICK_W-1:0] lag;
        int                i;
        lag = tick_now - aging_due;
        if (lag[TICK_W-1]) return;
        aging_due = tick_now + TICK_W'(aging_gap);
        aging_runs++;
        if (start + 1 >= LEVELS) return;
        moved_head = queue_head[start + 1];
        moved_tail = queue_tail[start + 1];
        moved_len  = queue_len[start + 1];
        for (i = start + 1; i + 1 < LEVELS; i++) begin
            queue_head[i] = queue_head[i + 1];
            queue_tail[i] = queue_tail[i + 1];
            queue_len[i]  = queue_len[i + 1];
        end
        queue_len[LEVELS - 1] = 0;
        if (moved_len != 0) begin
            if (queue_len[start] == 0) begin
                queue_head[start] = moved_head;
            end else begin
                chain_next[queue_tail[start]] = moved_head;
            end
            queue_tail[start] = moved_tail;
            queue_len[start] += moved_len;
        end
    endfunction

    function automatic t_status schedule_next(logic leave);
        logic [TID_W-1:0] tid;
        logic [TID_W-1:0] old_tid;
        int               lvl;
        int               old_lvl;
        bit               had;
        had     = running;
        old_tid = running_tid;
        old_lvl = running_level;
        if (!dequeue_best(tid, lvl)) begin
            if (had && !leave) return ST_KEPT;
            running = 1'b0;
            return ST_IDLE;
        end
        running_tid   = tid;
        running_level = RUN_LVL_W'(lvl);
        running       = 1'b1;
        if (lvl > deepest_level) deepest_level = lvl;
        age_below(lvl);
        slice_stop = tick_now + TICK_W'(lvl + 1) * TICK_W'(slice_ticks);
        if (had && !leave && waiting_total < THREADS) begin
            enqueue_thread(old_lvl + 1 < LEVELS ? old_lvl + 1 : LEVELS - 1, old_tid);
        end
        return ST_SWITCHED;
    endfunction

    function automatic t_result predict_step(t_kind kind, logic [TID_W-1:0] tid,
                                             logic leave);
        t_result r;
        t_status st;
        st = ST_DONE;
        case (kind)
            K_WAKE: begin
                if (waiting_total < THREADS) begin
                    enqueue_thread(0, tid);
                end else begin
                    dropped_wakes++;
                end
            end
            K_SCHEDULE: begin
                st = schedule_next(leave);
            end
            K_TICK: begin
                tick_now = tick_now + 1;
            end
            default: begin
            end
        endcase
        case (st)
            ST_SWITCHED: switch_count++;
            ST_KEPT:     kept_count++;
            ST_IDLE:     idle_count++;
            default:     ;
        endcase
        r.status         = st;
        r.run_valid      = running;
        r.run_thread     = running ? running_tid : '0;
        r.run_level      = running ? running_level : '0;
        r.slice_deadline = running ? slice_stop : '0;
        r.ready_total    = TOTAL_W'(waiting_total);
        return r;
    endfunction

    task automatic send_item(t_kind kind, logic [TID_W-1:0] tid, logic leave,
                             int unsigned gap, bit fixed, t_result want);
        t_result predicted;
        if (gap > 0) begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_bus.valid      <= 1'b1;
        item_bus.kind       <= kind;
        item_bus.thread_id  <= tid;
        item_bus.leave_mode <= leave;
        @(posedge i_clk);
        while (!item_bus.ready) @(posedge i_clk);
        predicted = predict_step(kind, tid, leave);
        predicted_runs.push_back(fixed ? want : predicted);
        items_sent++;
    endtask

    task automatic drain_results();
        item_bus.valid <= 1'b0;
        while (predicted_runs.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_settings(logic [CFG_DATA_W-1:0] slice,
                                  logic [CFG_DATA_W-1:0] gap);
        cfg_bus.valid     <= 1'b1;
        cfg_bus.reg_index <= CFG_SLICE_UNIT;
        cfg_bus.reg_data  <= slice;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.reg_index <= CFG_RELINK_INTERVAL;
        cfg_bus.reg_data  <= gap;
        do @(posedge i_clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        slice_ticks = slice;
        aging_gap   = gap;
        @(posedge i_clk);
    endtask

    task automatic run_traffic(int unsigned count, bit steady);
        int unsigned      n;
        int unsigned      burst_left;
        int unsigned      gap;
        int unsigned      pick;
        int unsigned      style;
        t_kind            kind;
        logic [TID_W-1:0] tid;
        logic             leave;
        burst_left = 0;
        style = 0;
        for (n = 0; n < count; n++) begin
            if (n % 16 == 0) begin
                pick = $urandom_range(0, 99);
                style = (pick < 50) ? 0 : ((pick < 85) ? 1 : 2);
            end
            gap = 0;
            if (!steady) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap = $urandom_range(1, 7);
                end else begin
                    burst_left--;
                end
            end
            pick  = $urandom_range(0, 99);
            tid   = TID_W'($urandom_range(0, THREADS - 1));
            leave = 1'($urandom_range(0, 1));
            if (style == 0) begin
                if (pick < 30) kind = K_WAKE;
                else if (pick < 65) kind = K_SCHEDULE;
                else if (pick < 93) kind = K_TICK;
                else kind = K_NOP;
            end else if (style == 1) begin
                if (pick < 8) kind = K_WAKE;
                else if (pick < 85) kind = K_SCHEDULE;
                else kind = K_TICK;
                if ($urandom_range(0, 9) != 0) leave = 1'b0;
            end else begin
                if (pick < 75) kind = K_WAKE;
                else if (pick < 90) kind = K_SCHEDULE;
                else kind = K_TICK;
            end
            send_item(kind, tid, leave, gap, 1'b0, '0);
        end
    endtask

    task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("Mismatch in %s at result %0d: expected %0h, got %0h",
                     field, results_seen, want, got);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        int unsigned style;
        int unsigned span;
        span  = 0;
        style = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                result_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
                hold_count++;
            end else begin
                if (span == 0) begin
                    span  = $urandom_range(10, 60);
                    style = $urandom_range(0, 3);
                end
                span--;
                case (style)
                    0:       result_bus.ready <= 1'b1;
                    1:       result_bus.ready <= 1'($urandom_range(0, 1));
                    2:       result_bus.ready <= (span % 3 != 0);
                    default: result_bus.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycle_count, predicted_runs.size());
            $display("[FAIL] regression broken");
            $finish;
        end else if (i_rst_n && result_bus.valid && result_bus.ready) begin
            results_seen++;
            if (predicted_runs.size() == 0) begin
                note_mismatch("unrequested result", 32'd0, 32'(result_bus.status));
            end else begin
                want = predicted_runs.pop_front();
                if (result_bus.status !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(result_bus.status));
                if (result_bus.run_valid !== want.run_valid)
                    note_mismatch("run_valid", 32'(want.run_valid),
                                  32'(result_bus.run_valid));
                if (result_bus.run_thread !== want.run_thread)
                    note_mismatch("run_thread", 32'(want.run_thread),
                                  32'(result_bus.run_thread));
                if (result_bus.run_level !== want.run_level)
                    note_mismatch("run_level", 32'(want.run_level),
                                  32'(result_bus.run_level));
                if (result_bus.slice_deadline !== want.slice_deadline)
                    note_mismatch("slice_deadline", want.slice_deadline,
                                  result_bus.slice_deadline);
                if (result_bus.ready_total !== want.ready_total)
                    note_mismatch("ready_total", 32'(want.ready_total),
                                  32'(result_bus.ready_total));
            end
        end
    end

    initial begin
        int i;
        int unsigned phase;
        i_rst_n             <= 1'b0;
        item_bus.valid      <= 1'b0;
        item_bus.kind       <= K_NOP;
        item_bus.thread_id  <= '0;
        item_bus.leave_mode <= 1'b0;
        cfg_bus.valid       <= 1'b0;
        cfg_bus.reg_index   <= CFG_SLICE_UNIT;
        cfg_bus.reg_data    <= '0;
        result_bus.ready    <= 1'b0;
        hold_request = 1'b0;
        for (i = 0; i < LEVELS; i++) begin
            queue_head[i] = '0;
            queue_tail[i] = '0;
            queue_len[i]  = 0;
        end
        for (i = 0; i < THREADS; i++) chain_next[i] = '0;
        waiting_total = 0;
        running_tid   = '0;
        running_level = '0;
        running       = 1'b0;
        tick_now      = '0;
        aging_due     = '0;
        slice_stop    = '0;
        slice_ticks   = SLICE_UNIT_RESET;
        aging_gap     = RELINK_INTERVAL_RESET;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < $size(directed_steps); i++) begin
            send_item(directed_steps[i].kind, directed_steps[i].tid,
                      directed_steps[i].leave, $urandom_range(0, 2),
                      directed_steps[i].fixed, directed_steps[i].want);
        end
        drain_results();

        for (phase = 0; phase < PHASES; phase++) begin
            apply_settings(slice_plan[phase], gap_plan[phase]);
            if (phase == 3) begin
                // Keep offering while the result side is held off so the block backs up.
                hold_request = 1'b1;
                run_traffic(40, 1'b1);
            end else if (phase == 4) begin
                for (i = 0; i < 70; i++) begin
                    send_item(K_WAKE, TID_W'($urandom_range(0, THREADS - 1)),
                              1'($urandom_range(0, 1)), 0, 1'b0, '0);
                end
            end
            run_traffic(25, phase == 1);
            drain_results();
            run_traffic(25, 1'b0);
            drain_results();
        end

        repeat (10) @(posedge i_clk);
        $display("Checked %0d results from %0d transactions: %0d switches, %0d kept, %0d idle.",
                 results_seen, items_sent, switch_count, kept_count, idle_count);
        $display("Deepest level %0d, %0d aging relinks, %0d wakes dropped when full, %0d holds.",
                 deepest_level, aging_runs, dropped_wakes, hold_count);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches in total", mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
